// ===== hdl/reconnect_supervisor_backoff_defines.svh =====
// ----------------------------------------------------------------------------
// Reconnect supervisor assertion macros
// Shared property shorthands for the supervisor's checker.
// ----------------------------------------------------------------------------
`ifndef RECONNECT_SUPERVISOR_BACKOFF_DEFINES_SVH
`define RECONNECT_SUPERVISOR_BACKOFF_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Reconnect supervisor package
// Payload types, phase and command codes and register defaults.
// ----------------------------------------------------------------------------
package rsb_pkg;

  localparam int unsigned TimerBitsDef = 12;
  localparam int unsigned RegW         = 12;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [RegW-1:0] SettleReset = 12'd60;
  localparam logic [RegW-1:0] BaseReset   = 12'd5;
  localparam logic [RegW-1:0] MaxReset    = 12'd300;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETTLE = 2'd0,
    REG_BASE   = 2'd1,
    REG_MAX    = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_ADDR = 2'd1,
    KIND_LINK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_JOIN  = 2'd1,
    CMD_LEAVE = 2'd2
  } cmd_e;

  localparam logic [2:0] PHC_WAIT    = 3'd0;
  localparam logic [2:0] PHC_SETTLE  = 3'd1;
  localparam logic [2:0] PHC_CONN    = 3'd2;
  localparam logic [2:0] PHC_LOST    = 3'd3;
  localparam logic [2:0] PHC_BACKOFF = 3'd4;

  typedef enum logic [4:0] {
    PH_WAIT    = 5'b00001,
    PH_SETTLE  = 5'b00010,
    PH_CONN    = 5'b00100,
    PH_LOST    = 5'b01000,
    PH_BACKOFF = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic       session_up;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      command;
    logic [2:0]      phase_code;
    logic [RegW-1:0] delay_now;
  } out_item_t;

  function automatic logic [2:0] phase_code_f(phase_e ph);
    logic [2:0] code;
    unique case (ph)
      PH_SETTLE:  code = PHC_SETTLE;
      PH_CONN:    code = PHC_CONN;
      PH_LOST:    code = PHC_LOST;
      PH_BACKOFF: code = PHC_BACKOFF;
      default:    code = PHC_WAIT;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/reconnect_supervisor_backoff.sv =====
// ----------------------------------------------------------------------------
// Reconnect supervisor with capped exponential backoff
// Tick-driven session supervisor issuing join and leave commands.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake              | Payload
//  in       | input     | in_valid_i / in_stall_o | in_data_i  (kind, session_up)
//  out      | output    | out_valid_o / out_stall_i | out_data_o (command, phase, delay)
//  cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low: the whole phase update is a
// single compare-and-select step on the state registers, done in the cycle
// the item transfers. The result is registered in the output register, or in
// the skid entry while the output is stalled; this two-entry buffer lets one
// more item in while a result is stalled. Reset restores the register defaults
// and the wait-network phase. Config writes are always accepted and registered.
// ----------------------------------------------------------------------------
module reconnect_supervisor_backoff #(
  parameter int unsigned TIMER_BITS = rsb_pkg::TimerBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rsb_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rsb_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rsb_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rsb_pkg::RegW-1:0]       cfg_data_i
);
  import rsb_pkg::*;

  localparam int unsigned CmpW = ((TIMER_BITS > RegW) ? TIMER_BITS : RegW) + 1;
  localparam logic [CmpW-1:0] TimerMax = CmpW'((1 << TIMER_BITS) - 1);

  logic [RegW-1:0]       settle_q, base_q, max_q;
  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] tick_q, tick_d;
  logic [RegW:0]         next_q, next_d;
  logic [RegW-1:0]       active_q, active_d;
  logic                  netup_q, netup_d;
  logic                  wake_q, wake_d;

  out_item_t out_q, skid_q, res;
  logic      out_valid_q, skid_valid_q;
  logic      acc, take;
  cmd_e      cmd;

  logic [CmpW-1:0] count_inc, settle_lim, active_lim;
  logic            settle_hit, active_hit;
  logic [RegW:0]   max_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign acc         = in_valid_i & ~skid_valid_q;
  assign take        = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleReset;
      base_q   <= BaseReset;
      max_q    <= MaxReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SETTLE: settle_q <= cfg_data_i;
        REG_BASE:   base_q   <= cfg_data_i;
        REG_MAX:    max_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Limits above the timer range act as the saturated timer value.
  always_comb begin
    count_inc  = CmpW'(tick_q) + CmpW'(1);
    settle_lim = (CmpW'(settle_q) > TimerMax) ? TimerMax : CmpW'(settle_q);
    active_lim = (CmpW'(active_q) > TimerMax) ? TimerMax : CmpW'(active_q);
    settle_hit = count_inc >= settle_lim;
    active_hit = count_inc >= active_lim;
    max_ext    = {1'b0, max_q};
  end

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    next_d   = next_q;
    active_d = active_q;
    netup_d  = netup_q;
    wake_d   = wake_q;
    cmd      = CMD_NONE;
    if (acc) begin
      unique case (in_data_i.kind)
        KIND_ADDR: begin
          netup_d = 1'b1;
          wake_d  = 1'b1;
        end
        KIND_LINK: netup_d = 1'b1;
        KIND_TICK: begin
          unique case (phase_q)
            PH_SETTLE, PH_LOST: begin
              if (in_data_i.session_up) begin
                tick_d = '0;
                if (phase_q == PH_SETTLE) begin
                  next_d  = {1'b0, base_q};
                  phase_d = PH_CONN;
                end else if (netup_q) begin
                  phase_d = PH_SETTLE;
                  cmd     = CMD_JOIN;
                end else begin
                  phase_d = PH_WAIT;
                end
              end else if (settle_hit) begin
                // Failed cycle: pick the capped delay, then double for next time while below the maximum.
                active_d = (next_q > max_ext) ? max_q : next_q[RegW-1:0];
                if (next_q < max_ext) begin
                  next_d = {next_q[RegW-1:0], 1'b0};
                end
                tick_d  = '0;
                phase_d = PH_BACKOFF;
                cmd     = CMD_LEAVE;
              end else if (tick_q != '1) begin
                tick_d = tick_q + 1'b1;
              end
            end
            PH_CONN: begin
              if (!in_data_i.session_up) begin
                phase_d = PH_LOST;
                tick_d  = '0;
              end
            end
            PH_BACKOFF: begin
              if (wake_q || active_hit) begin
                wake_d = 1'b0;
                tick_d = '0;
                if (netup_q) begin
                  phase_d = PH_SETTLE;
                  cmd     = CMD_JOIN;
                end else begin
                  phase_d = PH_WAIT;
                end
              end else if (tick_q != '1) begin
                tick_d = tick_q + 1'b1;
              end
            end
            default: begin
              if (netup_q) begin
                tick_d  = '0;
                phase_d = PH_SETTLE;
                cmd     = CMD_JOIN;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
    res.command    = cmd;
    res.phase_code = phase_code_f(phase_d);
    res.delay_now  = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      tick_q   <= '0;
      next_q   <= {1'b0, BaseReset};
      active_q <= '0;
      netup_q  <= 1'b0;
      wake_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      next_q   <= next_d;
      active_q <= active_d;
      netup_q  <= netup_d;
      wake_q   <= wake_d;
    end
  end

  // The skid entry fills only when a result arrives while the output is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      out_valid_q  <= skid_valid_q | acc;
      skid_valid_q <= 1'b0;
    end else if (acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (acc) begin
      skid_q <= res;
    end
  end

endmodule

// ===== hdl/rsb_checker.sv =====
// ----------------------------------------------------------------------------
// Reconnect supervisor checker
// Port-level properties of the supervisor, bound to the top level.
// ----------------------------------------------------------------------------
`include "reconnect_supervisor_backoff_defines.svh"

module rsb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input rsb_pkg::out_item_t          out_data_o
);
  import rsb_pkg::*;

  logic join_res, leave_res;

  assign join_res  = out_valid_o && (out_data_o.command == CMD_JOIN);
  assign leave_res = out_valid_o && (out_data_o.command == CMD_LEAVE);

  // A stalled result holds until it transfers.
  `RSB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_data_o), "stalled result changed")

  // A join always lands in the settle phase, a leave in backoff.
  `RSB_ASSERT_IMP(a_join_settle, clk_i, rst_ni, join_res,
                  out_data_o.phase_code == PHC_SETTLE, "join outside settle")
  `RSB_ASSERT_IMP(a_leave_backoff, clk_i, rst_ni, leave_res,
                  out_data_o.phase_code == PHC_BACKOFF, "leave outside backoff")

  // The input side only stalls after a stalled result took a second transfer.
  `RSB_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, $rose(in_stall_o),
                  $past(out_valid_o && out_stall_i && in_valid_i), "unexpected input stall")

endmodule

bind reconnect_supervisor_backoff rsb_checker u_rsb_checker (.*);
